>>> sv/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg - shared types and constants for the one-wire bus master
// Request/result payloads, queue entry, timing register set and opcodes.
// ----------------------------------------------------------------------------
`default_nettype none

package owb_pkg;

    // Request operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESET   = 3'd1;
    localparam logic [2:0] OP_WR_BIT  = 3'd2;
    localparam logic [2:0] OP_RD_BIT  = 3'd3;
    localparam logic [2:0] OP_WR_BYTE = 3'd4;
    localparam logic [2:0] OP_RD_BYTE = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_WRITE_SHORT    = 3'd0;
    localparam logic [2:0] REG_WRITE_LONG     = 3'd1;
    localparam logic [2:0] REG_READ_LOW       = 3'd2;
    localparam logic [2:0] REG_READ_SAMPLE    = 3'd3;
    localparam logic [2:0] REG_READ_RECOVERY  = 3'd4;
    localparam logic [2:0] REG_RESET_LOW      = 3'd5;
    localparam logic [2:0] REG_RESET_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_RESET_RECOVERY = 3'd7;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register reset values (microseconds)
    localparam logic [7:0]  RST_WRITE_SHORT    = 8'd8;
    localparam logic [7:0]  RST_WRITE_LONG     = 8'd72;
    localparam logic [7:0]  RST_READ_LOW       = 8'd1;
    localparam logic [7:0]  RST_READ_SAMPLE    = 8'd1;
    localparam logic [7:0]  RST_READ_RECOVERY  = 8'd80;
    localparam logic [10:0] RST_RESET_LOW      = 11'd500;
    localparam logic [10:0] RST_RESET_SAMPLE   = 11'd100;
    localparam logic [10:0] RST_RESET_RECOVERY = 11'd1000;

    localparam int TIMER_W = 11;

    // Request queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data;
        logic       bus_level;
    } t_req;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       presence;
        logic       rejected;
    } t_res;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_CMD,
        KIND_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] op;
        logic [7:0] data;
        logic       lvl;
    } t_qent;

    typedef struct packed {
        logic [7:0]  write_short_us;
        logic [7:0]  write_long_us;
        logic [7:0]  read_low_us;
        logic [7:0]  read_sample_us;
        logic [7:0]  read_recovery_us;
        logic [10:0] reset_low_us;
        logic [10:0] reset_sample_us;
        logic [10:0] reset_recovery_us;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/owb_front.sv
// ----------------------------------------------------------------------------
// owb_front - request intake
// Classifies each incoming request as tick, command or no-op for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_front (
    input  wire logic          i_in_valid,
    input  wire owb_pkg::t_req i_in_req,
    input  wire logic          i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output owb_pkg::t_qent     o_ent
);
    import owb_pkg::*;

    t_kind kind;

    always_comb begin
        case (i_in_req.operation) inside
            OP_TICK:              kind = KIND_TICK;
            [OP_RESET:OP_RD_BYTE]: kind = KIND_CMD;
            default:              kind = KIND_NOP;
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_ent.kind = kind;
        o_ent.op   = i_in_req.operation;
        o_ent.data = i_in_req.data;
        o_ent.lvl  = i_in_req.bus_level;
    end

endmodule

`default_nettype wire

>>> sv/owb_queue.sv
// ----------------------------------------------------------------------------
// owb_queue - short request FIFO
// Decouples request intake from the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire owb_pkg::t_qent i_wdata,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output owb_pkg::t_qent      o_rdata
);
    import owb_pkg::*;

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/owb_back.sv
// ----------------------------------------------------------------------------
// owb_back - bus slot sequencer
// Runs reset, write and read slots one phase transition per cycle unless
// starved or stalled, and holds the result register towards the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_back #(
    parameter int BIT_GAP_US = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire owb_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    input  wire owb_pkg::t_qent i_q_ent,
    output logic                o_pop,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output owb_pkg::t_res       o_out_res
);
    import owb_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_RST_REL,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REC,
        PH_RD_REL,
        PH_GAP
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [TIMER_W-1:0]   timer;
    } t_slot;

    localparam logic [TIMER_W-1:0] GAP_TICKS = TIMER_W'(BIT_GAP_US);

    t_phase             r_phase, n_phase;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [7:0]         r_shift, n_shift;
    logic [3:0]         r_bits, n_bits;
    logic [2:0]         r_active, n_active;
    logic               r_presence, n_presence;
    logic               r_out_valid;
    t_res               r_out;

    logic               advance, cont, done, rej;
    logic [TIMER_W-1:0] t_dec;
    t_slot              slot;
    t_res               res;

    // First phase of a bit slot
    function automatic t_slot slot_start(input logic [2:0] op, input logic bit0,
                                         input t_cfg cfg);
        t_slot s;
        if (op == OP_WR_BIT || op == OP_WR_BYTE) begin
            s.phase = PH_WR_LOW;
            s.timer = TIMER_W'(bit0 ? cfg.write_short_us : cfg.write_long_us);
        end else begin
            s.phase = PH_RD_LOW;
            s.timer = TIMER_W'(cfg.read_low_us);
        end
        return s;
    endfunction

    assign advance = i_q_valid && (!r_out_valid || !i_out_stall);
    assign t_dec   = (r_timer == '0) ? '0 : r_timer - 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_active   = r_active;
        n_presence = r_presence;
        cont       = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        slot       = slot_start(r_active, r_shift[0], i_cfg);

        case (i_q_ent.kind)
            KIND_CMD: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_active = i_q_ent.op;
                    if (i_q_ent.op == OP_RESET) begin
                        n_phase = PH_RST_LOW;
                        n_timer = i_cfg.reset_low_us;
                    end else begin
                        case (i_q_ent.op)
                            OP_WR_BIT:  n_shift = {7'd0, i_q_ent.data[0]};
                            OP_WR_BYTE: n_shift = i_q_ent.data;
                            default:    n_shift = 8'd0;
                        endcase
                        n_bits = (i_q_ent.op == OP_WR_BYTE || i_q_ent.op == OP_RD_BYTE)
                                 ? 4'd8 : 4'd1;
                        slot    = slot_start(i_q_ent.op, n_shift[0], i_cfg);
                        n_phase = slot.phase;
                        n_timer = slot.timer;
                    end
                end
            end
            KIND_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_timer = t_dec;
                    if (t_dec == '0) begin
                        case (r_phase)
                            PH_RST_LOW: begin
                                n_phase = PH_RST_WAIT;
                                n_timer = i_cfg.reset_sample_us;
                                cont    = (n_timer == '0);
                            end
                            PH_RST_WAIT: begin
                                n_presence = !i_q_ent.lvl;
                                n_phase    = PH_RST_REC;
                                n_timer    = i_cfg.reset_recovery_us;
                                cont       = (n_timer == '0);
                            end
                            PH_RST_REC, PH_RST_REL: begin
                                // recovery over: wait for the line to float high
                                if (!i_q_ent.lvl) begin
                                    n_phase = PH_RST_REL;
                                end else begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end
                            end
                            PH_WR_LOW: begin
                                n_phase = PH_WR_HIGH;
                                n_timer = TIMER_W'(r_shift[0] ? i_cfg.write_long_us
                                                              : i_cfg.write_short_us);
                                cont    = (n_timer == '0);
                            end
                            PH_WR_HIGH: begin
                                n_shift = r_shift >> 1;
                                n_bits  = r_bits - 4'd1;
                                if (r_active == OP_WR_BYTE) begin
                                    n_phase = PH_GAP;
                                    n_timer = GAP_TICKS;
                                    cont    = (GAP_TICKS == '0);
                                end else begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end
                            end
                            PH_RD_LOW: begin
                                n_phase = PH_RD_WAIT;
                                n_timer = TIMER_W'(i_cfg.read_sample_us);
                                cont    = (n_timer == '0);
                            end
                            PH_RD_WAIT: begin
                                n_shift = (r_active == OP_RD_BYTE)
                                          ? {i_q_ent.lvl, r_shift[7:1]}
                                          : {7'd0, i_q_ent.lvl};
                                n_phase = PH_RD_REC;
                                n_timer = TIMER_W'(i_cfg.read_recovery_us);
                                cont    = (n_timer == '0);
                            end
                            PH_RD_REC, PH_RD_REL: begin
                                if (!i_q_ent.lvl) begin
                                    n_phase = PH_RD_REL;
                                end else begin
                                    n_bits = r_bits - 4'd1;
                                    if (r_active == OP_RD_BYTE) begin
                                        n_phase = PH_GAP;
                                        n_timer = GAP_TICKS;
                                        cont    = (GAP_TICKS == '0);
                                    end else begin
                                        n_phase = PH_IDLE;
                                        done    = 1'b1;
                                    end
                                end
                            end
                            PH_GAP: begin
                                if (r_bits == 4'd0) begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end else begin
                                    n_phase = slot.phase;
                                    n_timer = slot.timer;
                                    cont    = (slot.timer == '0);
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.drive_low  = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                         (n_phase == PH_RD_LOW);
        res.busy_res   = (n_phase != PH_IDLE);
        res.done_res   = done;
        res.read_value = (done && (r_active == OP_RD_BIT || r_active == OP_RD_BYTE))
                         ? n_shift : 8'd0;
        res.presence   = n_presence;
        res.rejected   = rej;
    end

    // Head request stays in the queue while its tick still chains phases
    assign o_pop       = advance && !cont;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_active    <= '0;
            r_presence  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (advance) begin
                r_phase    <= n_phase;
                r_timer    <= n_timer;
                r_shift    <= n_shift;
                r_bits     <= n_bits;
                r_active   <= n_active;
                r_presence <= n_presence;
            end
            if (advance && !cont) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master - one-wire bus master paced by microsecond ticks
// Reset / bit / byte transfers with programmable slot timing over APB.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+--------------------------------
//  in       | i_in_valid / o_in_stall        | i_in_req  (operation,data,level)
//  out      | o_out_valid / i_out_stall      | o_out_res (one result/request)
//  cfg      | psel,penable,pwrite / pready=1 | paddr, pwdata, prdata
//
//  Flow: requests flow back to back unless the output stalls or a tick chains
//  phases; a request passes the queue, then the result register. A tick on
//  which a zero-length phase follows (zero timing register, zero bit gap) stays
//  queued for each such phase; a release check shares its recovery's cycle.
//  Reset: synchronous, active low; timing registers to defaults, queue empty.
//  Stalls: the result register is reloaded in the cycle it is taken; the
//  4-deep request queue stalls intake only when full.
//
`default_nettype none

module onewire_bus_master #(
    parameter int BIT_GAP_US = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire owb_pkg::t_req                  i_in_req,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output owb_pkg::t_res                       o_out_res,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [owb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [owb_pkg::PDATA_W-1:0]    pwdata,
    output logic [owb_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import owb_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic  push, pop, q_full, q_valid;
    t_qent ent_in, ent_head;

    // ---- register file ----------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_short_us    <= RST_WRITE_SHORT;
            r_cfg.write_long_us     <= RST_WRITE_LONG;
            r_cfg.read_low_us       <= RST_READ_LOW;
            r_cfg.read_sample_us    <= RST_READ_SAMPLE;
            r_cfg.read_recovery_us  <= RST_READ_RECOVERY;
            r_cfg.reset_low_us      <= RST_RESET_LOW;
            r_cfg.reset_sample_us   <= RST_RESET_SAMPLE;
            r_cfg.reset_recovery_us <= RST_RESET_RECOVERY;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WRITE_SHORT:    r_cfg.write_short_us    <= pwdata[7:0];
                REG_WRITE_LONG:     r_cfg.write_long_us     <= pwdata[7:0];
                REG_READ_LOW:       r_cfg.read_low_us       <= pwdata[7:0];
                REG_READ_SAMPLE:    r_cfg.read_sample_us    <= pwdata[7:0];
                REG_READ_RECOVERY:  r_cfg.read_recovery_us  <= pwdata[7:0];
                REG_RESET_LOW:      r_cfg.reset_low_us      <= pwdata[10:0];
                REG_RESET_SAMPLE:   r_cfg.reset_sample_us   <= pwdata[10:0];
                REG_RESET_RECOVERY: r_cfg.reset_recovery_us <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WRITE_SHORT:    prdata = PDATA_W'(r_cfg.write_short_us);
            REG_WRITE_LONG:     prdata = PDATA_W'(r_cfg.write_long_us);
            REG_READ_LOW:       prdata = PDATA_W'(r_cfg.read_low_us);
            REG_READ_SAMPLE:    prdata = PDATA_W'(r_cfg.read_sample_us);
            REG_READ_RECOVERY:  prdata = PDATA_W'(r_cfg.read_recovery_us);
            REG_RESET_LOW:      prdata = PDATA_W'(r_cfg.reset_low_us);
            REG_RESET_SAMPLE:   prdata = PDATA_W'(r_cfg.reset_sample_us);
            REG_RESET_RECOVERY: prdata = PDATA_W'(r_cfg.reset_recovery_us);
            default:            prdata = '0;
        endcase
    end

    // ---- front end: classify and enqueue ----------------------------------
    owb_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_ent      (ent_in)
    );

    owb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (ent_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (ent_head)
    );

    // ---- back end: slot sequencer and result register ---------------------
    owb_back #(
        .BIT_GAP_US (BIT_GAP_US)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_ent     (ent_head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

>>> sv/owb_checker.sv
// ----------------------------------------------------------------------------
// owb_checker - port-level checks for the one-wire bus master
// Bound to the top level; watches the result channel over time.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire owb_pkg::t_res o_out_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("result changed while stalled");

    // a completing request leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.done_res |-> !o_out_res.busy_res)
        else $error("done while still busy");

    // a rejected request cannot complete anything
    a_rej_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.rejected |-> !o_out_res.done_res)
        else $error("rejected and done together");

    // read data only on completion
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.read_value != 8'd0) |-> o_out_res.done_res)
        else $error("read value outside completion");

    // the line is only pulled low during a command
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.drive_low |-> o_out_res.busy_res)
        else $error("line driven while idle");

endmodule

bind onewire_bus_master owb_checker u_owb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

`default_nettype wire
